// File: sv/multichannel_biquad_iir_filter_top_assert.svh
// Assertion macros for the multichannel biquad filter.
// Used by the top level; needs nothing else.
`ifndef MULTICHANNEL_BIQUAD_IIR_FILTER_TOP_ASSERT_SVH
`define MULTICHANNEL_BIQUAD_IIR_FILTER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define BQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define BQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/biquad_pkg.sv
// Shared types, constants and saturation helpers for the biquad filter.
// No dependencies.
package biquad_pkg;

    localparam int CHAN_W   = 3;
    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 24;
    localparam int DELAY_W  = 40;
    localparam int ACC_W    = 42;
    localparam int FRAC_W   = 20;
    localparam int CFG_IDX_W = 3;

    localparam logic signed [COEF_W-1:0] COEF_ONE  = 24'sh100000;
    localparam logic signed [COEF_W-1:0] COEF_ZERO = 24'sh000000;

    localparam logic signed [DELAY_W-1:0] DELAY_MAX = 40'sh7F_FFFF_FFFF;
    localparam logic signed [DELAY_W-1:0] DELAY_MIN = 40'sh80_0000_0000;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

    // Half an output LSB, for round half up
    localparam logic signed [ACC_W-1:0] ROUND_HALF = 42'sd524288;

    // Coefficient register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FF_COEF_0 = 3'd0,
        CFG_FF_COEF_1 = 3'd1,
        CFG_FF_COEF_2 = 3'd2,
        CFG_FB_COEF_1 = 3'd3,
        CFG_FB_COEF_2 = 3'd4
    } t_cfg_idx;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_U,
        ST_ACC_Y,
        ST_MUL_FB,
        ST_WRITE
    } t_state;

    // State memory strobes
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_mem_ctl;

    // Take 20 fractional bits off a rounded sum and clamp to 16 bits signed
    function automatic logic signed [SAMPLE_W-1:0] sat_sample(
        input logic signed [ACC_W-1:0] v
    );
        logic signed [ACC_W-FRAC_W-1:0] s;
        s = v[ACC_W-1:FRAC_W];
        if (s > 22'sd32767) begin
            return SAMPLE_MAX;
        end else if (s < -22'sd32768) begin
            return SAMPLE_MIN;
        end else begin
            return s[SAMPLE_W-1:0];
        end
    endfunction

    // Clamp a delay update to 40 bits signed
    function automatic logic signed [DELAY_W-1:0] sat_delay(
        input logic signed [ACC_W-1:0] v
    );
        if (v > 42'(DELAY_MAX)) begin
            return DELAY_MAX;
        end else if (v < 42'(DELAY_MIN)) begin
            return DELAY_MIN;
        end else begin
            return v[DELAY_W-1:0];
        end
    endfunction

endpackage

// File: sv/biquad_state_mem.sv
// Per-channel delay state memory {z2, z1} with a registered read.
// Depends on biquad_pkg. Entries read as zero until first written after reset.
module biquad_state_mem #(
    parameter int  CHANNELS = 8,
    localparam int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  biquad_pkg::t_mem_ctl      i_ctl,
    input  logic [IDX_W-1:0]          i_rd_idx,
    input  logic [IDX_W-1:0]          i_wr_idx,
    input  logic [2*biquad_pkg::DELAY_W-1:0] i_wr_data,
    output logic [2*biquad_pkg::DELAY_W-1:0] o_rd_data
);

    localparam int DATA_W = 2 * biquad_pkg::DELAY_W;

    logic [DATA_W-1:0]   r_mem [CHANNELS];
    logic [CHANNELS-1:0] r_valid;
    logic [DATA_W-1:0]   r_rd_data;
    logic                r_rd_valid;

    // Storage array: write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_idx] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_idx];
        end
    end

    // Written flags, cleared at reset so the state starts at zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_ctl.wr_en) begin
                r_valid[i_wr_idx] <= 1'b1;
            end
            if (i_ctl.rd_en) begin
                r_rd_valid <= r_valid[i_rd_idx];
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

// File: sv/multichannel_biquad_iir_filter_top.sv
// Top level of the multichannel transposed direct form II biquad filter.
// Depends on biquad_pkg, biquad_state_mem and the assertion macro header.
//
// Each sample transfer carries a channel on tuser and a signed 16-bit sample on
// tdata; one filtered sample comes back per input, with its channel, in order.
// Coefficients b0, b1, b2, a1, a2 are signed Q4.20 written through the config
// port (index 0..4, other indexes ignored); the user must write them only while
// no sample is in flight, which the block does not enforce. Channel state sits
// in a small synchronous memory, read on acceptance and written back last; an
// item passes the state read with the feedforward products, the rounding step,
// the feedback products and the write-back, and the next item is taken in the
// write-back step with the state forwarded if it hits the same channel. The
// result is registered in the rounding step, which stalls until the output is
// free. Channel numbers at or above CHANNELS wrap onto the state store modulo
// CHANNELS. All state reads as zero after reset with no clearing pass.
`include "multichannel_biquad_iir_filter_top_assert.svh"

module multichannel_biquad_iir_filter_top #(
    parameter int CHANNELS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [15:0] sample_in
    input  logic [2:0]  i_s_axis_tuser,   // [2:0] chan
    // Output stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [15:0] sample_out
    output logic [2:0]  o_m_axis_tuser,   // [2:0] chan_out
    // Coefficient write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);

    localparam int IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int DLY_W   = biquad_pkg::DELAY_W;
    localparam int ACC_W   = biquad_pkg::ACC_W;
    localparam int SMP_W   = biquad_pkg::SAMPLE_W;
    localparam int CF_W    = biquad_pkg::COEF_W;
    localparam int CH_W    = biquad_pkg::CHAN_W;
    localparam int EXT_W   = 7;
    localparam logic [EXT_W-1:0] CHAN_LIM = EXT_W'(CHANNELS);

    // Coefficients
    logic signed [CF_W-1:0] r_b0, r_b1, r_b2, r_a1, r_a2;

    // Sequencer
    biquad_pkg::t_state r_state, n_state;
    logic               s_fire;
    logic               out_free;
    biquad_pkg::t_mem_ctl mem_ctl;

    // Item registers
    logic signed [SMP_W-1:0] r_u;
    logic [CH_W-1:0]         r_chan;
    logic [IDX_W-1:0]        r_idx, n_idx;
    logic                    r_fwd, n_fwd;
    logic [CH_W-1:0]         chan_red;
    logic [EXT_W-1:0]        chan_ext;

    // Datapath
    logic signed [DLY_W-1:0] r_z1, r_z2, r_wb_z1, r_wb_z2, n_z1, n_z2;
    logic signed [DLY_W-1:0] r_pa, r_pb, prod_a, prod_b;
    logic signed [ACC_W-1:0] r_acc1, r_acc2, n_acc1, y_sum;
    logic signed [SMP_W-1:0] r_ys, n_ys;
    logic signed [CF_W-1:0]  mul_a_coef, mul_b_coef;
    logic signed [SMP_W-1:0] mul_a_data, mul_b_data;
    logic [2*DLY_W-1:0]      mem_rd_data;

    // Output register
    logic                    r_out_valid;
    logic [CH_W-1:0]         r_out_chan;
    logic signed [SMP_W-1:0] r_out_sample;

    assign o_cfg_ready = 1'b1;

    // Coefficient registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b0 <= biquad_pkg::COEF_ONE;
            r_b1 <= biquad_pkg::COEF_ZERO;
            r_b2 <= biquad_pkg::COEF_ZERO;
            r_a1 <= biquad_pkg::COEF_ZERO;
            r_a2 <= biquad_pkg::COEF_ZERO;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                biquad_pkg::CFG_FF_COEF_0: r_b0 <= i_cfg_data;
                biquad_pkg::CFG_FF_COEF_1: r_b1 <= i_cfg_data;
                biquad_pkg::CFG_FF_COEF_2: r_b2 <= i_cfg_data;
                biquad_pkg::CFG_FB_COEF_1: r_a1 <= i_cfg_data;
                biquad_pkg::CFG_FB_COEF_2: r_a2 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Channel to state index: chan modulo CHANNELS by repeated subtraction
    always_comb begin
        chan_red = i_s_axis_tuser;
        for (int k = 0; k < (1 << CH_W); k++) begin
            if ({4'd0, chan_red} >= CHAN_LIM) begin
                chan_red = CH_W'({4'd0, chan_red} - CHAN_LIM);
            end
        end
        chan_ext = EXT_W'(chan_red);
        n_idx    = chan_ext[IDX_W-1:0];
    end

    // Next state and handshake
    always_comb begin
        n_state         = r_state;
        o_s_axis_tready = 1'b0;
        out_free        = !r_out_valid || i_m_axis_tready;
        case (r_state)
            biquad_pkg::ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid) begin
                    n_state = biquad_pkg::ST_MUL_U;
                end
            end
            biquad_pkg::ST_MUL_U: begin
                n_state = biquad_pkg::ST_ACC_Y;
            end
            biquad_pkg::ST_ACC_Y: begin
                if (out_free) begin
                    n_state = biquad_pkg::ST_MUL_FB;
                end
            end
            biquad_pkg::ST_MUL_FB: begin
                n_state = biquad_pkg::ST_WRITE;
            end
            biquad_pkg::ST_WRITE: begin
                o_s_axis_tready = 1'b1;
                n_state = i_s_axis_tvalid ? biquad_pkg::ST_MUL_U : biquad_pkg::ST_IDLE;
            end
            default: begin
                n_state = biquad_pkg::ST_IDLE;
            end
        endcase
        s_fire        = i_s_axis_tvalid && o_s_axis_tready;
        mem_ctl.rd_en = s_fire;
        mem_ctl.wr_en = (r_state == biquad_pkg::ST_WRITE);
        // Same channel as the one being written back: take the fresh values
        n_fwd         = (r_state == biquad_pkg::ST_WRITE) && (n_idx == r_idx);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= biquad_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Multiplier operand selection: feedforward pass, then feedback pass
    always_comb begin
        mul_a_coef = r_b0;
        mul_a_data = r_u;
        mul_b_coef = r_b1;
        mul_b_data = r_u;
        case (r_state)
            biquad_pkg::ST_ACC_Y: begin
                mul_a_coef = r_b2;
            end
            biquad_pkg::ST_MUL_FB: begin
                mul_a_coef = r_a1;
                mul_a_data = r_ys;
                mul_b_coef = r_a2;
                mul_b_data = r_ys;
            end
            default: ;
        endcase
    end

    assign prod_a = mul_a_coef * mul_a_data;
    assign prod_b = mul_b_coef * mul_b_data;

    // Output rounding and delay updates
    always_comb begin
        y_sum  = ACC_W'(r_pa) + ACC_W'(r_z1) + biquad_pkg::ROUND_HALF;
        n_ys   = biquad_pkg::sat_sample(y_sum);
        n_acc1 = ACC_W'(r_pb) + ACC_W'(r_z2);
        n_z1   = biquad_pkg::sat_delay(r_acc1 - ACC_W'(r_pa));
        n_z2   = biquad_pkg::sat_delay(r_acc2 - ACC_W'(r_pb));
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_u    <= i_s_axis_tdata;
            r_chan <= i_s_axis_tuser;
            r_idx  <= n_idx;
        end
        case (r_state)
            biquad_pkg::ST_MUL_U: begin
                r_pa <= prod_a;
                r_pb <= prod_b;
                r_z1 <= r_fwd ? r_wb_z1 : mem_rd_data[DLY_W-1:0];
                r_z2 <= r_fwd ? r_wb_z2 : mem_rd_data[2*DLY_W-1:DLY_W];
            end
            biquad_pkg::ST_ACC_Y: begin
                if (out_free) begin
                    r_ys   <= n_ys;
                    r_acc1 <= n_acc1;
                    r_pa   <= prod_a;
                end
            end
            biquad_pkg::ST_MUL_FB: begin
                r_acc2 <= ACC_W'(r_pa);
                r_pa   <= prod_a;
                r_pb   <= prod_b;
            end
            biquad_pkg::ST_WRITE: begin
                r_wb_z1 <= n_z1;
                r_wb_z2 <= n_z2;
            end
            default: ;
        endcase
    end

    // Forwarding flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (s_fire) begin
            r_fwd <= n_fwd;
        end
    end

    // Output register: loaded once the rounded sample is ready
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == biquad_pkg::ST_ACC_Y && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == biquad_pkg::ST_ACC_Y && out_free) begin
            r_out_chan   <= r_chan;
            r_out_sample <= n_ys;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_sample;
    assign o_m_axis_tuser  = r_out_chan;

    // Channel state store
    biquad_state_mem #(
        .CHANNELS (CHANNELS)
    ) u_state_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (mem_ctl),
        .i_rd_idx  (n_idx),
        .i_wr_idx  (r_idx),
        .i_wr_data ({n_z2, n_z1}),
        .o_rd_data (mem_rd_data)
    );

    // Checks
    `BQ_ASSERT_NEXT(a_fire_starts, i_clk, i_rst_n, s_fire,
        r_state == biquad_pkg::ST_MUL_U, "accepted sample did not start the multiply pass")
    `BQ_ASSERT_NOW(a_fwd_origin, i_clk, i_rst_n, (r_state == biquad_pkg::ST_MUL_U) && r_fwd,
        $past(r_state) == biquad_pkg::ST_WRITE, "forwarding without a write-back in flight")
    `BQ_ASSERT_NOW(a_out_source, i_clk, i_rst_n, $rose(r_out_valid),
        $past(r_state) == biquad_pkg::ST_ACC_Y, "result appeared outside the rounding step")

endmodule
